### hdl/tkd_pkg.sv
// shared constants and helpers for the terminal key decoder
package tkd_pkg;

	localparam int unsigned KEY_W = 21;

	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;

	localparam logic [KEY_W-1:0] KEY_UP    = 21'h10;
	localparam logic [KEY_W-1:0] KEY_DOWN  = 21'h0E;
	localparam logic [KEY_W-1:0] KEY_RIGHT = 21'h06;
	localparam logic [KEY_W-1:0] KEY_LEFT  = 21'h02;
	localparam logic [KEY_W-1:0] KEY_HOME  = 21'h01;
	localparam logic [KEY_W-1:0] KEY_BKSP  = 21'h08;
	localparam logic [KEY_W-1:0] KEY_END   = 21'h05;

	// continuation bytes a lead byte needs; 0 ascii, 4 invalid lead
	function automatic logic [2:0] lead_need(input logic [7:0] b);
		logic [2:0] n;
		if (b < 8'h80) n = 3'd0;
		else if (b >= 8'hC2 && b <= 8'hDF) n = 3'd1;
		else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd2;
		else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd3;
		else n = 3'd4;
		return n;
	endfunction

endpackage

### hdl/terminal_key_decoder.sv
// terminal key decoder: utf-8 assembly and csi escape decoding of raw bytes
// a byte passes the input register and then the result register before its key code is on m_tdata
// throughput: one byte per cycle while the sink keeps up, set by the state update stage
// a full result register with a stalled sink holds the input stage
// reset (arst_n low) clears phase, utf-8 count, csi parameter and all valids
module terminal_key_decoder
	import tkd_pkg::*;
#(
	parameter int unsigned PARAM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [20:0] key_code, [23:21] zero
);

	// escape phase codes
	localparam logic [1:0] PH_NORMAL = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_CSI    = 2'd2;

	localparam int unsigned MUL_W = PARAM_WIDTH + 4;
	localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = {PARAM_WIDTH{1'b1}};

	// input stage
	logic                   in_valid_s1;
	logic [7:0]             in_byte_s1;

	// decoder state
	logic [1:0]             phase_q;
	logic [7:0]             pend_q [3];
	logic [1:0]             pend_cnt_q;
	logic [PARAM_WIDTH-1:0] param_q;
	logic [3:0]             param_cnt_q;

	// result register
	logic                   out_valid_q;
	logic [KEY_W-1:0]       key_code_q;

	logic                   out_ok;
	logic                   go;

	// next-state and result of the byte in stage 1
	logic                   emit;
	logic [KEY_W-1:0]       emit_code;
	logic [1:0]             phase_d;
	logic [1:0]             pend_cnt_d;
	logic                   pend_we;
	logic [1:0]             pend_idx;
	logic [PARAM_WIDTH-1:0] param_d;
	logic [3:0]             param_cnt_d;

	logic [7:0]             c;
	logic [7:0]             b0;
	logic [2:0]             need_b0;
	logic [2:0]             need_c;
	logic [7:0]             lo;
	logic [7:0]             hi;
	logic                   restart;
	logic [MUL_W-1:0]       param_mul;
	logic [3:0]             param_cnt_inc;

	assign out_ok   = !out_valid_q || m_tready;
	assign go       = in_valid_s1 && out_ok;
	assign s_tready = !in_valid_s1 || out_ok;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, key_code_q};

	assign c       = in_byte_s1;
	assign b0      = pend_q[0];
	assign need_b0 = lead_need(b0);
	assign need_c  = lead_need(c);

	// param * 10 + digit, checked for overflow in the top bits
	assign param_mul = ({4'b0000, param_q} << 3) + ({4'b0000, param_q} << 1)
		+ MUL_W'(c - CH_ZERO);

	assign param_cnt_inc = (param_cnt_q == 4'hF) ? param_cnt_q : param_cnt_q + 4'd1;

	always_comb begin
		emit        = 1'b0;
		emit_code   = '0;
		phase_d     = phase_q;
		pend_cnt_d  = pend_cnt_q;
		pend_we     = 1'b0;
		pend_idx    = 2'd0;
		param_d     = param_q;
		param_cnt_d = param_cnt_q;
		lo          = 8'h80;
		hi          = 8'hBF;
		restart     = 1'b0;

		unique case (phase_q)
			PH_NORMAL: begin
				if (c == CH_ESC) begin
					phase_d = PH_ESC;
				end else if (c == CH_DEL) begin
					emit      = 1'b1;
					emit_code = KEY_BKSP;
				end else if (pend_cnt_q == 2'd0) begin
					restart = 1'b1;
				end else begin
					// narrowed second-byte ranges after special lead bytes
					if (pend_cnt_q == 2'd1) begin
						if (b0 == 8'hE0) lo = 8'hA0;
						else if (b0 == 8'hED) hi = 8'h9F;
						else if (b0 == 8'hF0) lo = 8'h90;
						else if (b0 == 8'hF4) hi = 8'h8F;
					end
					if (need_b0 < 3'd1 || need_b0 > 3'd3 || c < lo || c > hi) begin
						// bad continuation: drop pending, reparse as lead
						pend_cnt_d = 2'd0;
						restart    = 1'b1;
					end else if ({1'b0, pend_cnt_q} < need_b0) begin
						pend_we    = 1'b1;
						pend_idx   = pend_cnt_q;
						pend_cnt_d = pend_cnt_q + 2'd1;
					end else begin
						pend_cnt_d = 2'd0;
						emit       = 1'b1;
						case (need_b0)
							3'd1: emit_code = {10'd0, b0[4:0], c[5:0]};
							3'd2: emit_code = {5'd0, b0[3:0], pend_q[1][5:0], c[5:0]};
							default: emit_code = {b0[2:0], pend_q[1][5:0],
								pend_q[2][5:0], c[5:0]};
						endcase
					end
				end

				if (restart) begin
					if (need_c == 3'd0) begin
						emit      = 1'b1;
						emit_code = {13'd0, c};
					end else if (need_c <= 3'd3) begin
						pend_we    = 1'b1;
						pend_idx   = 2'd0;
						pend_cnt_d = 2'd1;
					end
				end
			end
			PH_ESC: begin
				if (c == CH_LBRK) begin
					param_d     = '0;
					param_cnt_d = 4'd0;
					phase_d     = PH_CSI;
				end else begin
					phase_d = PH_NORMAL;
				end
			end
			PH_CSI: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					if (param_cnt_q == 4'd0) begin
						if (param_mul[MUL_W-1:PARAM_WIDTH] != 4'd0) param_d = PARAM_MAX;
						else param_d = param_mul[PARAM_WIDTH-1:0];
					end
				end else begin
					param_cnt_d = param_cnt_inc;
					if (c != CH_SEMI) begin
						phase_d = PH_NORMAL;
						case (c)
							CH_A: begin emit = 1'b1; emit_code = KEY_UP; end
							CH_B: begin emit = 1'b1; emit_code = KEY_DOWN; end
							CH_C: begin emit = 1'b1; emit_code = KEY_RIGHT; end
							CH_D: begin emit = 1'b1; emit_code = KEY_LEFT; end
							CH_TILDE: begin
								// only a single parameter selects an editing key
								if (param_cnt_inc == 4'd1) begin
									case (param_q)
										PARAM_WIDTH'(1): begin
											emit = 1'b1; emit_code = KEY_HOME;
										end
										PARAM_WIDTH'(3): begin
											emit = 1'b1; emit_code = KEY_BKSP;
										end
										PARAM_WIDTH'(4): begin
											emit = 1'b1; emit_code = KEY_END;
										end
										PARAM_WIDTH'(5): begin
											emit = 1'b1; emit_code = KEY_UP;
										end
										PARAM_WIDTH'(6): begin
											emit = 1'b1; emit_code = KEY_DOWN;
										end
										default: emit = 1'b0;
									endcase
								end
							end
							default: emit = 1'b0;
						endcase
					end
				end
			end
			default: begin
				// unused phase code falls back to normal
				phase_d = PH_NORMAL;
			end
		endcase
	end

	// input register: holds a byte until the state stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NORMAL;
			pend_cnt_q  <= 2'd0;
			param_q     <= '0;
			param_cnt_q <= 4'd0;
		end else if (go) begin
			phase_q     <= phase_d;
			pend_cnt_q  <= pend_cnt_d;
			param_q     <= param_d;
			param_cnt_q <= param_cnt_d;
		end
	end

	// pending utf-8 bytes, meaningful only below the count
	always_ff @(posedge clk) begin
		if (go && pend_we) begin
			pend_q[pend_idx] <= c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ok) begin
			out_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			key_code_q <= emit_code;
		end
	end

endmodule

### tb/sv/terminal_key_decoder_tb.sv
// self-checking testbench for the terminal key decoder
`timescale 1ns / 100ps

module terminal_key_decoder_tb;
	import tkd_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 9;
	localparam int PARAM_W = 16;
	localparam int unsigned PARAM_SAT = (1 << PARAM_W) - 1;
	localparam int PCOUNT_SAT = 15;
	localparam int DRAIN_CYCLES = 20;
	localparam longint CYCLE_LIMIT = 1000000;

	// vt key numbers carried by esc [ n ~
	localparam int unsigned VT_HOME = 1;
	localparam int unsigned VT_DELETE = 3;
	localparam int unsigned VT_END = 4;
	localparam int unsigned VT_PGUP = 5;
	localparam int unsigned VT_PGDN = 6;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESC = 2'd1,
		PH_CSI = 2'd2
	} dec_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;

	// decoder mirror state
	dec_phase_t dec_phase = PH_NORMAL;
	logic [7:0] utf_buf[3];
	int utf_cnt = 0;
	int unsigned csi_val = 0;
	int csi_cnt = 0;

	logic [KEY_W-1:0] keys_due[$];
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	longint cycles = 0;
	bit no_idle = 1'b0;
	int sink_hold = 0;

	terminal_key_decoder #(
		.PARAM_WIDTH(PARAM_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// continuation bytes after a lead byte; -1 for a byte that cannot lead
	function automatic int utf8_tail(input logic [7:0] lead);
		if (lead[7] == 1'b0) return 0;
		if (lead >= 8'hC2 && lead <= 8'hDF) return 1;
		if (lead >= 8'hE0 && lead <= 8'hEF) return 2;
		if (lead >= 8'hF0 && lead <= 8'hF4) return 3;
		return -1;
	endfunction

	task automatic utf8_lead(input logic [7:0] b, output logic hit,
			output logic [KEY_W-1:0] cp);
		int t;
		t = utf8_tail(b);
		hit = 1'b0;
		cp = '0;
		if (t == 0) begin
			hit = 1'b1;
			cp = KEY_W'(b);
		end else if (t > 0) begin
			utf_buf[0] = b;
			utf_cnt = 1;
		end
	endtask

	task automatic utf8_feed(input logic [7:0] b, output logic hit,
			output logic [KEY_W-1:0] cp);
		int need;
		logic [7:0] lo;
		logic [7:0] hi;
		hit = 1'b0;
		cp = '0;
		if (utf_cnt == 0) begin
			utf8_lead(b, hit, cp);
			return;
		end
		need = utf8_tail(utf_buf[0]);
		lo = 8'h80;
		hi = 8'hBF;
		// second byte range narrows for overlong, surrogate and beyond-max leads
		if (utf_cnt == 1) begin
			case (utf_buf[0])
				8'hE0: lo = 8'hA0;
				8'hED: hi = 8'h9F;
				8'hF0: lo = 8'h90;
				8'hF4: hi = 8'h8F;
				default: ;
			endcase
		end
		if (b < lo || b > hi) begin
			// drop what was pending, this byte starts over
			utf_cnt = 0;
			utf8_lead(b, hit, cp);
		end else if (utf_cnt < need) begin
			utf_buf[utf_cnt] = b;
			utf_cnt++;
		end else begin
			case (need)
				1: cp = {10'd0, utf_buf[0][4:0], b[5:0]};
				2: cp = {5'd0, utf_buf[0][3:0], utf_buf[1][5:0], b[5:0]};
				default: cp = {utf_buf[0][2:0], utf_buf[1][5:0], utf_buf[2][5:0], b[5:0]};
			endcase
			hit = 1'b1;
			utf_cnt = 0;
		end
	endtask

	task automatic csi_feed(input logic [7:0] b, output logic hit,
			output logic [KEY_W-1:0] key);
		int unsigned v;
		hit = 1'b0;
		key = '0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			// only the first parameter is kept
			if (csi_cnt == 0) begin
				v = csi_val * 10 + (b - CH_ZERO);
				csi_val = (v > PARAM_SAT) ? PARAM_SAT : v;
			end
			return;
		end
		if (csi_cnt < PCOUNT_SAT) csi_cnt++;
		if (b == CH_SEMI) return;
		dec_phase = PH_NORMAL;
		case (b)
			CH_A: begin hit = 1'b1; key = KEY_UP; end
			CH_B: begin hit = 1'b1; key = KEY_DOWN; end
			CH_C: begin hit = 1'b1; key = KEY_RIGHT; end
			CH_D: begin hit = 1'b1; key = KEY_LEFT; end
			CH_TILDE: begin
				if (csi_cnt == 1) begin
					hit = 1'b1;
					case (csi_val)
						VT_HOME: key = KEY_HOME;
						VT_DELETE: key = KEY_BKSP;
						VT_END: key = KEY_END;
						VT_PGUP: key = KEY_UP;
						VT_PGDN: key = KEY_DOWN;
						default: hit = 1'b0;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	// advance the mirror by one byte and queue the key it yields, if any
	task automatic decode_byte(input logic [7:0] b);
		logic hit;
		logic [KEY_W-1:0] key;
		hit = 1'b0;
		key = '0;
		case (dec_phase)
			PH_NORMAL: begin
				if (b == CH_ESC) begin
					dec_phase = PH_ESC;
				end else if (b == CH_DEL) begin
					hit = 1'b1;
					key = KEY_BKSP;
				end else begin
					utf8_feed(b, hit, key);
				end
			end
			PH_ESC: begin
				if (b == CH_LBRK) begin
					csi_val = 0;
					csi_cnt = 0;
					dec_phase = PH_CSI;
				end else begin
					dec_phase = PH_NORMAL;
				end
			end
			PH_CSI: csi_feed(b, hit, key);
			default: dec_phase = PH_NORMAL;
		endcase
		if (hit) keys_due.push_back(key);
	endtask

	// one input transaction, then an optional idle gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		n_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_code_point(input int unsigned cp);
		if (cp < 32'h80) begin
			send_byte(cp[7:0]);
		end else if (cp < 32'h800) begin
			send_byte(8'hC0 | cp[10:6]);
			send_byte(8'h80 | cp[5:0]);
		end else if (cp < 32'h10000) begin
			send_byte(8'hE0 | cp[15:12]);
			send_byte(8'h80 | cp[11:6]);
			send_byte(8'h80 | cp[5:0]);
		end else begin
			send_byte(8'hF0 | cp[20:18]);
			send_byte(8'h80 | cp[17:12]);
			send_byte(8'h80 | cp[11:6]);
			send_byte(8'h80 | cp[5:0]);
		end
	endtask

	function automatic int unsigned random_code_point();
		int unsigned edges[8] = '{32'h80, 32'h7FF, 32'h800, 32'hFFFF, 32'hD7FF,
			32'hE000, 32'h10000, 32'h10FFFF};
		int r;
		if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 7)];
		r = $urandom_range(0, 9);
		if (r < 3) return $urandom_range(0, 32'h7F);
		if (r < 5) return $urandom_range(32'h80, 32'h7FF);
		if (r < 8) return $urandom_range(32'h800, 32'hFFFF);
		return $urandom_range(32'h10000, 32'h10FFFF);
	endfunction

	// esc [ p;p;... fin with random parameter text
	task automatic send_csi(input int n_params, input int digits_max,
			input logic [7:0] fin_byte);
		int nd;
		send_byte(CH_ESC);
		send_byte(CH_LBRK);
		for (int i = 0; i < n_params; i++) begin
			if (i > 0) send_byte(CH_SEMI);
			if ($urandom_range(0, 2) == 0) begin
				send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
			end else begin
				nd = $urandom_range(0, digits_max);
				repeat (nd) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
			end
		end
		send_byte(fin_byte);
	endtask

	function automatic logic [7:0] random_final();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return CH_TILDE;
		if (r < 85) return 8'(CH_A + $urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_directed();
		logic [7:0] seq[$];
		seq = '{8'h00, 8'hFF, CH_DEL, 8'hC3, 8'hA9,
			CH_ESC, CH_LBRK, CH_A,
			CH_ESC, CH_LBRK, 8'h33, CH_TILDE,
			8'hE0, 8'h80,
			8'hC3, CH_ESC, 8'h58, 8'hA9,
			8'hC3, CH_DEL, 8'hA9,
			CH_ESC, CH_LBRK, CH_TILDE,
			CH_ESC, CH_LBRK, 8'h5A};
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// mostly well-formed code points, some stray bytes
	task automatic test_utf8_stream(input int count);
		int stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
			else send_code_point(random_code_point());
		end
	endtask

	task automatic test_csi_sequences(input int count);
		int stop_at;
		int r;
		int np;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) np = 1;
			else if (r < 75) np = 0;
			else if (r < 90) np = $urandom_range(2, 3);
			else np = $urandom_range(14, 20);
			r = $urandom_range(0, 99);
			if (r < 85) begin
				send_csi(np, ($urandom_range(0, 4) == 0) ? 8 : 2, random_final());
			end else if (r < 93) begin
				// esc not followed by a bracket
				send_byte(CH_ESC);
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_code_point(random_code_point());
			end
		end
	endtask

	// byte soup weighted toward the bytes the decoder cares about
	task automatic test_mixed_noise(input int count);
		int stop_at;
		int r;
		logic [7:0] b;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 15) b = CH_ESC;
			else if (r < 23) b = CH_DEL;
			else if (r < 33) b = CH_LBRK;
			else if (r < 40) b = 8'(CH_ZERO + $urandom_range(0, 9));
			else if (r < 44) b = CH_SEMI;
			else if (r < 50) b = ($urandom_range(0, 1) == 0) ? CH_TILDE
				: 8'(CH_A + $urandom_range(0, 3));
			else if (r < 75) b = 8'($urandom_range(8'h80, 8'hFF));
			else b = 8'($urandom_range(0, 255));
			send_byte(b);
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back(input int count);
		int stop_at;
		stop_at = n_sent + count;
		no_idle = 1'b1;
		while (n_sent < stop_at) begin
			if ($urandom_range(0, 1) == 0) send_csi(1, 2, random_final());
			else send_code_point(random_code_point());
		end
		no_idle = 1'b0;
	endtask

	// sink side backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			sink_hold = pick_gap();
			m_tready <= (sink_hold == 0);
			if (sink_hold > 0) sink_hold--;
		end
	end

	// compare every output transaction with the oldest queued key
	always @(posedge clk) begin : check_keys
		logic [KEY_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (keys_due.size() == 0) begin
				$error("key_code: none expected, actual %h", m_tdata[KEY_W-1:0]);
				n_errors++;
			end else begin
				want = keys_due.pop_front();
				if (m_tdata[KEY_W-1:0] !== want) begin
					$error("key_code: expected %h, actual %h", want, m_tdata[KEY_W-1:0]);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d keys outstanding", cycles,
				keys_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_utf8_stream(550);
		test_csi_sequences(600);
		test_mixed_noise(450);
		test_back_to_back(250);

		s_tvalid <= 1'b0;
		while (keys_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (keys_due.size() != 0) begin
			$error("key_code: %0d expected keys never arrived", keys_due.size());
			n_errors++;
		end
		$display("%0d bytes sent, %0d key codes checked, %0d mismatches", n_sent,
			n_checked, n_errors);
		$display("utf-8 of every length, csi cursor and tilde keys, broken and noisy input");
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
hdl/tkd_pkg.sv
hdl/terminal_key_decoder.sv
tb/sv/terminal_key_decoder_tb.sv
